@@ sv/fx248_pkg.sv @@
// Shared constants and types for the 24.8 fixed / double converter.
// No dependencies; used by all fx248 modules and the top level.
package fx248_pkg;

    localparam logic [1:0] OP_D2F = 2'd0;  // double -> fixed
    localparam logic [1:0] OP_F2D = 2'd1;  // fixed -> double
    localparam logic [1:0] OP_F2I = 2'd2;  // fixed -> integer, toward zero
    localparam logic [1:0] OP_I2F = 2'd3;  // integer -> fixed

    localparam int FRAC_BITS_DEF = 8;
    localparam int FRAC_BITS_MAX = 16;

    localparam logic [10:0] DBL_BIAS = 11'd1023;
    localparam logic [10:0] DBL_EXP_ALL1 = 11'h7FF;

    // double -> fixed result
    typedef struct packed {
        logic signed [31:0] fixed;
        logic               flag;
    } t_d2f_res;

endpackage

@@ sv/fixed_24_8_float_converter.sv @@
// Top level of the 24.8 fixed-point / double converter.
// Depends on fx248_pkg, fx248_dbl2fix, fx248_fix2dbl.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  request | in        | i_valid / o_stall    | i_operation, i_double_in, i_fixed_in,
//          |           |                      | i_integer_in
//  result  | out       | o_valid / i_stall    | o_fixed_out, o_double_out, o_integer_out,
//          |           |                      | o_range_flag
//
// Two register stages: an input register and a result register, with the
// conversion logic between them. A request is taken into the input register,
// and o_valid rises when the result register loads, which can wait behind a
// stalled result; one request per cycle is sustained while i_stall stays low.
// Reset (i_rst_n low, synchronous) empties both stages.
// A stalled result holds; the input register still takes a request while the
// result waits, and o_stall rises only when both stages are full.
module fixed_24_8_float_converter #(
    parameter int FRACTION_BITS = fx248_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [63:0]        i_double_in,
    input  logic signed [31:0] i_fixed_in,
    input  logic signed [23:0] i_integer_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_fixed_out,
    output logic [63:0]        o_double_out,
    output logic signed [23:0] o_integer_out,
    output logic               o_range_flag
);

    // input register
    logic               r_s1_valid;
    logic [1:0]         r_op;
    logic [63:0]        r_dbl;
    logic signed [31:0] r_fix;
    logic signed [23:0] r_int;

    // result register
    logic               r_out_valid;
    logic signed [31:0] r_fixed_out;
    logic [63:0]        r_double_out;
    logic signed [23:0] r_integer_out;
    logic               r_range_flag;

    logic signed [31:0] n_fixed_out;
    logic [63:0]        n_double_out;
    logic signed [23:0] n_integer_out;
    logic               n_range_flag;

    logic adv_out;   // result register loads
    logic load_in;   // input register loads

    fx248_pkg::t_d2f_res d2f_res;
    logic [63:0]         f2d_dbl;

    logic [31:0]        frac_mask;
    logic signed [31:0] quo;
    logic signed [31:0] quo_tz;
    logic signed [40:0] i_scaled;

    assign adv_out = !(r_out_valid && i_stall);
    assign o_stall = r_s1_valid && !adv_out;
    assign load_in = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load_in) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in && i_valid) begin
            r_op  <= i_operation;
            r_dbl <= i_double_in;
            r_fix <= i_fixed_in;
            r_int <= i_integer_in;
        end
    end

    fx248_dbl2fix #(.FRACTION_BITS(FRACTION_BITS)) u_dbl2fix (
        .i_double (r_dbl),
        .o_res    (d2f_res)
    );

    fx248_fix2dbl #(.FRACTION_BITS(FRACTION_BITS)) u_fix2dbl (
        .i_fixed  (r_fix),
        .o_double (f2d_dbl)
    );

    // fixed -> integer: arithmetic shift, then step toward zero on
    // negative values with dropped fraction bits
    assign frac_mask = (32'd1 << FRACTION_BITS) - 32'd1;
    assign quo       = r_fix >>> FRACTION_BITS;
    assign quo_tz    = (r_fix[31] && ((r_fix & frac_mask) != 32'd0)) ? quo + 32'sd1 : quo;

    // integer -> fixed, wide enough for the largest fraction width
    assign i_scaled = {{17{r_int[23]}}, r_int} <<< FRACTION_BITS;

    always_comb begin
        n_fixed_out   = '0;
        n_double_out  = '0;
        n_integer_out = '0;
        n_range_flag  = 1'b0;
        case (r_op)
            fx248_pkg::OP_D2F: begin
                n_fixed_out  = d2f_res.fixed;
                n_range_flag = d2f_res.flag;
            end
            fx248_pkg::OP_F2D: begin
                n_double_out = f2d_dbl;
            end
            fx248_pkg::OP_F2I: begin
                if (quo_tz > 32'sd8388607) begin
                    n_integer_out = 24'sh7F_FFFF;
                end else if (quo_tz < -32'sd8388608) begin
                    n_integer_out = 24'sh80_0000;
                end else begin
                    n_integer_out = quo_tz[23:0];
                end
            end
            fx248_pkg::OP_I2F: begin
                if (i_scaled > 41'sd2147483647) begin
                    n_fixed_out = 32'sh7FFF_FFFF;
                end else if (i_scaled < -41'sd2147483648) begin
                    n_fixed_out = 32'sh8000_0000;
                end else begin
                    n_fixed_out = i_scaled[31:0];
                end
            end
            default: begin
                n_fixed_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_fixed_out   <= n_fixed_out;
            r_double_out  <= n_double_out;
            r_integer_out <= n_integer_out;
            r_range_flag  <= n_range_flag;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fixed_out   = r_fixed_out;
    assign o_double_out  = r_double_out;
    assign o_integer_out = r_integer_out;
    assign o_range_flag  = r_range_flag;

    // input side backs up only behind a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("o_stall without a held result");

    // a held result is never dropped
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("held result lost");

    // the flag only comes with a double -> fixed result
    a_flag_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_flag) |-> (o_double_out == 64'd0 && o_integer_out == 24'sd0))
        else $error("range flag with foreign result fields");

    // a double result leaves the other fields clear
    a_double_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_double_out != 64'd0) |->
        (o_fixed_out == 32'sd0 && o_integer_out == 24'sd0 && !o_range_flag))
        else $error("double result with foreign result fields");

endmodule

@@ sv/fx248_dbl2fix.sv @@
// Double to signed fixed conversion, round half to even, saturating.
// Depends on fx248_pkg.
module fx248_dbl2fix #(
    parameter int FRACTION_BITS = fx248_pkg::FRAC_BITS_DEF
) (
    input  logic [63:0]         i_double,
    output fx248_pkg::t_d2f_res o_res
);

    logic               sgn;
    logic [10:0]        expo;
    logic [51:0]        frac;
    logic [52:0]        mant;
    logic signed [12:0] exp_s;
    logic [5:0]         sh;
    logic [105:0]       full;
    logic [31:0]        int_part;
    logic               rnd;
    logic               sticky;
    logic [32:0]        mag;
    logic [32:0]        neg_mag;

    assign sgn   = i_double[63];
    assign expo  = i_double[62:52];
    assign frac  = i_double[51:0];
    assign mant  = {(expo != 11'd0), frac};
    // binary exponent of the scaled value
    assign exp_s = $signed({2'b00, expo}) - $signed({2'b00, fx248_pkg::DBL_BIAS})
                   + 13'(FRACTION_BITS);
    assign sh    = 6'(13'sd52 - exp_s);
    assign full  = {mant, 53'd0} >> sh;
    assign int_part = full[84:53];
    assign rnd      = full[52];
    assign sticky   = |full[51:0];
    assign mag      = {1'b0, int_part} + 33'(rnd & (sticky | int_part[0]));
    assign neg_mag  = ~mag + 33'd1;

    always_comb begin
        o_res.fixed = '0;
        o_res.flag  = 1'b0;
        if (expo == fx248_pkg::DBL_EXP_ALL1 && frac != 52'd0) begin
            o_res.flag = 1'b1;                    // NaN
        end else if (exp_s > 13'sd31) begin
            o_res.flag  = 1'b1;                   // |x| * 2^FRACTION_BITS >= 2^32, or infinity
            o_res.fixed = sgn ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (exp_s < -13'sd1) begin
            o_res.fixed = '0;                     // scaled value below one half
        end else if (sgn) begin
            if (mag > 33'h0_8000_0000) begin
                o_res.flag  = 1'b1;
                o_res.fixed = 32'sh8000_0000;
            end else begin
                o_res.fixed = neg_mag[31:0];
            end
        end else begin
            if (mag > 33'h0_7FFF_FFFF) begin
                o_res.flag  = 1'b1;
                o_res.fixed = 32'sh7FFF_FFFF;
            end else begin
                o_res.fixed = mag[31:0];
            end
        end
    end

endmodule

@@ sv/fx248_fix2dbl.sv @@
// Signed fixed to exact double: leading-one search and normalize.
// Depends on fx248_pkg.
module fx248_fix2dbl #(
    parameter int FRACTION_BITS = fx248_pkg::FRAC_BITS_DEF
) (
    input  logic signed [31:0] i_fixed,
    output logic [63:0]        o_double
);

    logic        sgn;
    logic [31:0] mag;
    logic [4:0]  lead;
    logic [31:0] norm;
    logic [10:0] expo;

    assign sgn = i_fixed[31];
    assign mag = sgn ? (~i_fixed + 32'd1) : i_fixed;

    always_comb begin
        lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) begin
                lead = 5'(i);
            end
        end
    end

    assign norm = mag << (~lead);
    assign expo = fx248_pkg::DBL_BIAS + 11'(lead) - 11'(FRACTION_BITS);

    always_comb begin
        if (mag == 32'd0) begin
            o_double = '0;
        end else begin
            o_double = {sgn, expo, norm[30:0], 21'd0};
        end
    end

endmodule

@@ test/fixed_24_8_float_converter_tb.sv @@
// Self-checking testbench for the 24.8 fixed / double converter.
// Depends on fx248_pkg and the fixed_24_8_float_converter RTL.
`timescale 1ns / 100ps

module fixed_24_8_float_converter_tb;

    typedef struct {
        logic [1:0]         op;
        logic [63:0]        dbl;
        logic signed [31:0] fix;
        logic signed [23:0] intg;
    } t_conv_req;

    typedef struct {
        logic signed [31:0] fix;
        logic [63:0]        dbl;
        logic signed [23:0] intg;
        logic               flag;
    } t_conv_res;

    localparam longint FIX_HI = 64'sd2147483647;
    localparam longint FIX_LO = -64'sd2147483648;
    localparam longint I24_HI = 64'sd8388607;
    localparam longint I24_LO = -64'sd8388608;

    // Nearest 24.8 value of a raw double, ties to even; saturates and flags
    // out-of-range and NaN inputs.
    function automatic t_conv_res round_to_fixed(input logic [63:0] bits);
        t_conv_res r;
        real       v;
        real       scaled;
        real       rem;
        longint    t;
        r = '{default: '0};
        if (bits[62:52] == fx248_pkg::DBL_EXP_ALL1 && bits[51:0] != '0) begin
            r.flag = 1'b1;
            return r;
        end
        v = $bitstoreal(bits);
        scaled = v * 256.0;
        if (scaled >= 4294967296.0) begin
            r.flag = 1'b1;
            r.fix = FIX_HI[31:0];
            return r;
        end
        if (scaled <= -4294967296.0) begin
            r.flag = 1'b1;
            r.fix = FIX_LO[31:0];
            return r;
        end
        // cast rounds; pull back to truncation toward zero
        t = longint'(scaled);
        if (scaled >= 0.0 && real'(t) > scaled) t = t - 1;
        if (scaled < 0.0 && real'(t) < scaled) t = t + 1;
        rem = scaled - real'(t);
        if (rem > 0.5 || (rem == 0.5 && t[0])) t = t + 1;
        if (rem < -0.5 || (rem == -0.5 && t[0])) t = t - 1;
        if (t > FIX_HI) begin
            r.flag = 1'b1;
            t = FIX_HI;
        end else if (t < FIX_LO) begin
            r.flag = 1'b1;
            t = FIX_LO;
        end
        r.fix = t[31:0];
        return r;
    endfunction

    function automatic t_conv_res convert(input t_conv_req q);
        t_conv_res r;
        longint    w;
        r = '{default: '0};
        case (q.op)
            fx248_pkg::OP_D2F: r = round_to_fixed(q.dbl);
            fx248_pkg::OP_F2D: r.dbl = $realtobits(real'(longint'(q.fix)) / 256.0);
            fx248_pkg::OP_F2I: begin
                w = longint'(q.fix) / 256;
                w = (w > I24_HI) ? I24_HI : (w < I24_LO) ? I24_LO : w;
                r.intg = w[23:0];
            end
            default: begin
                w = longint'(q.intg) * 256;
                w = (w > FIX_HI) ? FIX_HI : (w < FIX_LO) ? FIX_LO : w;
                r.fix = w[31:0];
            end
        endcase
        return r;
    endfunction

    class conv_scoreboard;
        t_conv_res pending[$];
        int        errors;
        int        checked;
        int        op_seen[4];
        int        flags_seen;

        function void note_request(t_conv_req q);
            t_conv_res r;
            r = convert(q);
            pending.push_back(r);
            op_seen[q.op]++;
            if (r.flag) flags_seen++;
        endfunction

        function void check_result(t_conv_res got);
            t_conv_res exp_r;
            checked++;
            if (pending.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.fix !== exp_r.fix) begin
                $error("fixed_out: expected %0d, got %0d", exp_r.fix, got.fix);
                errors++;
            end
            if (got.dbl !== exp_r.dbl) begin
                $error("double_out: expected %h, got %h", exp_r.dbl, got.dbl);
                errors++;
            end
            if (got.intg !== exp_r.intg) begin
                $error("integer_out: expected %0d, got %0d", exp_r.intg, got.intg);
                errors++;
            end
            if (got.flag !== exp_r.flag) begin
                $error("range_flag: expected %0b, got %0b", exp_r.flag, got.flag);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_operation;
    logic [63:0]        i_double_in;
    logic signed [31:0] i_fixed_in;
    logic signed [23:0] i_integer_in;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_fixed_out;
    logic [63:0]        o_double_out;
    logic signed [23:0] o_integer_out;
    logic               o_range_flag;

    conv_scoreboard sb;
    bit             calm;  // suppresses idling on both sides

    fixed_24_8_float_converter u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: checks each accepted result, then picks the next stall.
    always @(posedge i_clk) begin
        t_conv_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.fix = o_fixed_out;
            got.dbl = o_double_out;
            got.intg = o_integer_out;
            got.flag = o_range_flag;
            sb.check_result(got);
        end
        i_stall <= !calm && ($urandom_range(99) < 12);
    end

    // Holds one request on the port until it is taken.
    task automatic send_request(input t_conv_req q);
        while (!calm && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= q.op;
        i_double_in <= q.dbl;
        i_fixed_in <= q.fix;
        i_integer_in <= q.intg;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(q);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [63:0] d,
                           input logic signed [31:0] f, input logic signed [23:0] n);
        t_conv_req q;
        q.op = op;
        q.dbl = d;
        q.fix = f;
        q.intg = n;
        send_request(q);
    endtask

    // Mostly doubles of moderate size, some exact ties, some raw bit patterns.
    function automatic logic [63:0] pick_double();
        logic [63:0] b;
        int          sel;
        sel = $urandom_range(99);
        b = {$urandom(), $urandom()};
        if (sel < 50) begin
            b[62:52] = 11'($urandom_range(1023 + 25, 1023 - 12));
        end else if (sel < 70) begin
            b = $realtobits(real'($signed($urandom())) / 512.0);
        end else if (sel < 75) begin
            b[62:52] = fx248_pkg::DBL_EXP_ALL1;
        end
        return b;
    endfunction

    function automatic t_conv_req random_request();
        t_conv_req q;
        q.op = 2'($urandom_range(3));
        q.dbl = pick_double();
        q.fix = $urandom();
        if ($urandom_range(3) == 0) q.fix = 32'($signed(q.fix) >>> $urandom_range(31));
        q.intg = 24'($urandom());
        if ($urandom_range(3) == 0) q.intg = 24'($signed(q.intg) >>> $urandom_range(23));
        return q;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_operation = fx248_pkg::OP_D2F;
        i_double_in = '0;
        i_fixed_in = '0;
        i_integer_in = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zeros, signs, ties, NaN, infinities, saturation edges.
        send_op(fx248_pkg::OP_D2F, $realtobits(0.0), 0, 0);
        send_op(fx248_pkg::OP_D2F, 64'h8000_0000_0000_0000, 0, 0);   // negative zero
        send_op(fx248_pkg::OP_D2F, $realtobits(1.0 / 512.0), 0, 0);  // tie -> 0
        send_op(fx248_pkg::OP_D2F, $realtobits(3.0 / 512.0), 0, 0);  // tie -> 2
        send_op(fx248_pkg::OP_D2F, $realtobits(-3.0 / 512.0), 0, 0);
        send_op(fx248_pkg::OP_D2F, 64'h7FF8_0000_0000_0001, 0, 0);   // NaN
        send_op(fx248_pkg::OP_D2F, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);   // NaN, all ones
        send_op(fx248_pkg::OP_D2F, 64'h7FF0_0000_0000_0000, 0, 0);   // +inf
        send_op(fx248_pkg::OP_D2F, 64'hFFF0_0000_0000_0000, 0, 0);   // -inf
        send_op(fx248_pkg::OP_D2F, $realtobits(8388608.0), 0, 0);    // just above max
        send_op(fx248_pkg::OP_D2F, $realtobits(-8388608.0), 0, 0);   // exactly min
        send_op(fx248_pkg::OP_D2F, $realtobits(8388607.999), 0, 0);  // rounds over the top
        send_op(fx248_pkg::OP_D2F, 64'h0000_0000_0000_0001, 0, 0);   // smallest denormal
        send_op(fx248_pkg::OP_D2F, 64'h7FEF_FFFF_FFFF_FFFF, 0, 0);   // largest finite
        send_op(fx248_pkg::OP_F2D, 0, 32'sh7FFF_FFFF, 0);
        send_op(fx248_pkg::OP_F2D, 0, 32'sh8000_0000, 0);
        send_op(fx248_pkg::OP_F2D, 0, -1, 0);
        send_op(fx248_pkg::OP_F2D, 0, 0, 0);
        send_op(fx248_pkg::OP_F2I, 0, -255, 0);
        send_op(fx248_pkg::OP_F2I, 0, 32'sh7FFF_FFFF, 0);
        send_op(fx248_pkg::OP_F2I, 0, 32'sh8000_0000, 0);
        send_op(fx248_pkg::OP_I2F, 0, 0, 24'sh7F_FFFF);
        send_op(fx248_pkg::OP_I2F, 0, 0, 24'sh80_0000);
        send_op(fx248_pkg::OP_I2F, 0, 0, -1);

        // Sender waits for every result before the random part.
        drain();
        @(posedge i_clk);

        for (int k = 0; k < 500; k++) begin
            calm = (k >= 200 && k < 300);
            send_request(random_request());
        end
        calm = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        $display("checked %0d results: d2f %0d, f2d %0d, f2i %0d, i2f %0d, %0d range flags",
                 sb.checked, sb.op_seen[fx248_pkg::OP_D2F], sb.op_seen[fx248_pkg::OP_F2D],
                 sb.op_seen[fx248_pkg::OP_F2I], sb.op_seen[fx248_pkg::OP_I2F],
                 sb.flags_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
